// ===== rtl/point_grid_histogram_accumulator_core_assert.svh =====
// Assertion helpers for the histogram core checker.
`ifndef POINT_GRID_HISTOGRAM_ACCUMULATOR_CORE_ASSERT_SVH
`define POINT_GRID_HISTOGRAM_ACCUMULATOR_CORE_ASSERT_SVH

// Same-cycle implication, skipped while reset is high.
`define PGHA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("histogram core check failed");

// Next-cycle implication, skipped while reset is high.
`define PGHA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("histogram core check failed");

`endif

// ===== rtl/pgha_pkg.sv =====
package pgha_pkg;

   localparam int MAX_WIDTH  = 128;
   localparam int MAX_HEIGHT = 128;
   localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
   localparam int IDX_BITS   = (CELLS > 1) ? $clog2(CELLS) : 1;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 8;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VALUE_MODE  = 2'd2;

   localparam logic [1:0] ACT_ACCUMULATE = 2'd0;
   localparam logic [1:0] ACT_READ       = 2'd1;
   localparam logic [1:0] ACT_READ_CLEAR = 2'd2;

   localparam logic [1:0] ST_ACCUMULATED = 2'd0;
   localparam logic [1:0] ST_OUTSIDE     = 2'd1;
   localparam logic [1:0] ST_SKIPPED     = 2'd2;
   localparam logic [1:0] ST_READ_DONE   = 2'd3;

   localparam logic [15:0] COUNT_LIMIT = 16'd65534;
   localparam logic signed [47:0] SUM_HI = {1'b0, {47{1'b1}}};
   localparam logic signed [47:0] SUM_LO = {1'b1, {47{1'b0}}};

   typedef struct packed {
      logic [1:0]          action;
      logic signed [15:0]  pixel_x;
      logic signed [15:0]  pixel_y;
      logic signed [31:0]  attr_value;
      logic                attr_invalid;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [15:0]         cell_count;
      logic signed [47:0]  cell_sum;
   } rsp_type;

   typedef struct packed {
      logic [15:0]         count;
      logic signed [47:0]  sum;
   } cell_type;

   typedef struct packed {
      logic                in_grid;
      logic [IDX_BITS-1:0] idx;
   } loc_type;

endpackage

// ===== rtl/pgha_cell_ram.sv =====
module pgha_cell_ram (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [pgha_pkg::IDX_BITS-1:0] wr_addr,
   input  pgha_pkg::cell_type           wr_data,
   input  logic                         rd_en,
   input  logic [pgha_pkg::IDX_BITS-1:0] rd_addr,
   output pgha_pkg::cell_type           rd_data
);

   pgha_pkg::cell_type mem [pgha_pkg::CELLS];
   pgha_pkg::cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pgha_locate.sv =====
module pgha_locate (
   input  logic signed [15:0] pixel_x,
   input  logic signed [15:0] pixel_y,
   input  logic [7:0]         grid_width,
   input  logic [7:0]         grid_height,
   output pgha_pkg::loc_type  loc
);

   logic [15:0] w_ext;
   logic [15:0] h_ext;
   logic [15:0] w_eff;
   logic [15:0] h_eff;
   logic [15:0] x_u;
   logic [15:0] y_u;
   logic [31:0] lin;

   always_comb begin
      w_ext = 16'(grid_width);
      h_ext = 16'(grid_height);
      w_eff = (w_ext > 16'(pgha_pkg::MAX_WIDTH))  ? 16'(pgha_pkg::MAX_WIDTH)  : w_ext;
      h_eff = (h_ext > 16'(pgha_pkg::MAX_HEIGHT)) ? 16'(pgha_pkg::MAX_HEIGHT) : h_ext;
      x_u   = {1'b0, pixel_x[14:0]};
      y_u   = {1'b0, pixel_y[14:0]};
      lin   = 32'(y_u) * 32'(pgha_pkg::MAX_WIDTH) + 32'(x_u);
      loc.in_grid = !pixel_x[15] && !pixel_y[15] && (x_u < w_eff) && (y_u < h_eff);
      loc.idx     = lin[pgha_pkg::IDX_BITS-1:0];
   end

endmodule

// ===== rtl/pgha_update.sv =====
module pgha_update (
   input  pgha_pkg::req_type  req,
   input  logic               in_grid,
   input  logic               value_mode,
   input  pgha_pkg::cell_type cur,
   output logic               wr_req,
   output pgha_pkg::cell_type nxt,
   output pgha_pkg::rsp_type  rsp
);

   logic signed [48:0] sum_wide;
   logic signed [47:0] sum_sat;
   logic [15:0]        cnt_inc;

   always_comb begin
      sum_wide = {cur.sum[47], cur.sum} + {{17{req.attr_value[31]}}, req.attr_value};
      if (sum_wide[48] != sum_wide[47]) begin
         sum_sat = sum_wide[48] ? pgha_pkg::SUM_LO : pgha_pkg::SUM_HI;
      end else begin
         sum_sat = sum_wide[47:0];
      end
      cnt_inc = (cur.count >= pgha_pkg::COUNT_LIMIT) ? pgha_pkg::COUNT_LIMIT
                                                     : cur.count + 16'd1;

      wr_req         = 1'b0;
      nxt            = cur;
      rsp.status     = pgha_pkg::ST_READ_DONE;
      rsp.cell_count = cur.count;
      rsp.cell_sum   = cur.sum;

      if (!in_grid) begin
         rsp.status     = pgha_pkg::ST_OUTSIDE;
         rsp.cell_count = '0;
         rsp.cell_sum   = '0;
      end else if (req.action == pgha_pkg::ACT_ACCUMULATE) begin
         if (value_mode && req.attr_invalid) begin
            rsp.status = pgha_pkg::ST_SKIPPED;
         end else begin
            wr_req    = 1'b1;
            nxt.count = cnt_inc;
            if (value_mode) begin
               nxt.sum = sum_sat;
            end
            rsp.status     = pgha_pkg::ST_ACCUMULATED;
            rsp.cell_count = nxt.count;
            rsp.cell_sum   = nxt.sum;
         end
      end else if (req.action == pgha_pkg::ACT_READ_CLEAR) begin
         wr_req = 1'b1;
         nxt    = '0;
      end
   end

endmodule

// ===== rtl/point_grid_histogram_accumulator_core.sv =====
// Path: RAM read and stage-1 registers, then update and result register driving rsp_valid.
// One item per cycle if not stalled; a write to the cell read in the same cycle is forwarded.
// The cell RAM has one read and one write port; each item reads once and writes at most once.
// Reset: synchronous, active high; config returns to 128 x 128, frequency mode.
// After reset a clearing pass zeroes all 16384 cells, one per cycle; req_ready stays low.
module point_grid_histogram_accumulator_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  pgha_pkg::req_type                      req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output pgha_pkg::rsp_type                      rsp_payload,
   input  logic                                   csr_write_en,
   input  logic [pgha_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [pgha_pkg::CSR_DATA_BITS-1:0]     csr_data
);

   logic [7:0]                    grid_width_ff;
   logic [7:0]                    grid_height_ff;
   logic                          value_mode_ff;
   logic                          clearing_ff;
   logic [pgha_pkg::IDX_BITS-1:0] clear_addr_ff;
   logic                          s1_valid_ff;
   pgha_pkg::req_type             s1_req_ff;
   logic                          s1_in_grid_ff;
   logic [pgha_pkg::IDX_BITS-1:0] s1_idx_ff;
   logic                          s1_hit_ff;
   pgha_pkg::cell_type            fwd_ff;
   logic                          rsp_valid_ff;
   pgha_pkg::rsp_type             rsp_ff;

   logic                          s1_hit_in;
   logic                          advance;
   logic                          fire;
   logic                          accept;
   pgha_pkg::loc_type             loc;
   pgha_pkg::cell_type            rd_data;
   pgha_pkg::cell_type            cur;
   pgha_pkg::cell_type            nxt;
   pgha_pkg::rsp_type             rsp_next;
   logic                          upd_wr;
   logic                          item_wr;
   logic                          ram_wr_en;
   logic [pgha_pkg::IDX_BITS-1:0] ram_wr_addr;
   pgha_pkg::cell_type            ram_wr_data;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign fire      = s1_valid_ff && advance;
   assign req_ready = !clearing_ff && (!s1_valid_ff || advance);
   assign accept    = req_valid && req_ready;
   assign item_wr   = fire && upd_wr;
   assign s1_hit_in = item_wr && (s1_idx_ff == loc.idx);
   assign cur       = s1_hit_ff ? fwd_ff : rd_data;

   pgha_locate u_locate (
      .pixel_x     (req_payload.pixel_x),
      .pixel_y     (req_payload.pixel_y),
      .grid_width  (grid_width_ff),
      .grid_height (grid_height_ff),
      .loc         (loc)
   );

   pgha_update u_update (
      .req        (s1_req_ff),
      .in_grid    (s1_in_grid_ff),
      .value_mode (value_mode_ff),
      .cur        (cur),
      .wr_req     (upd_wr),
      .nxt        (nxt),
      .rsp        (rsp_next)
   );

   always_comb begin
      if (clearing_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clear_addr_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = item_wr;
         ram_wr_addr = s1_idx_ff;
         ram_wr_data = nxt;
      end
   end

   pgha_cell_ram u_cell_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (loc.idx),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= 8'd128;
         grid_height_ff <= 8'd128;
         value_mode_ff  <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            pgha_pkg::CSR_GRID_WIDTH:  grid_width_ff  <= csr_data[7:0];
            pgha_pkg::CSR_GRID_HEIGHT: grid_height_ff <= csr_data[7:0];
            pgha_pkg::CSR_VALUE_MODE:  value_mode_ff  <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clearing_ff) begin
         clear_addr_ff <= clear_addr_ff + pgha_pkg::IDX_BITS'(1);
         if (clear_addr_ff == pgha_pkg::IDX_BITS'(pgha_pkg::CELLS - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff     <= req_payload;
         s1_in_grid_ff <= loc.in_grid;
         s1_idx_ff     <= loc.idx;
         s1_hit_ff     <= s1_hit_in;
      end
      if (item_wr) begin
         fwd_ff <= nxt;
      end
      if (fire) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/pgha_checker.sv =====
`include "point_grid_histogram_accumulator_core_assert.svh"

module pgha_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input pgha_pkg::rsp_type rsp_payload
);

   logic rsp_stall;
   logic rsp_outside;
   logic rsp_zero;
   logic count_ok;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_outside = rsp_valid && (rsp_payload.status == pgha_pkg::ST_OUTSIDE);
   assign rsp_zero    = (rsp_payload.cell_count == 16'd0) && (rsp_payload.cell_sum == 48'sd0);
   assign count_ok    = rsp_payload.cell_count <= pgha_pkg::COUNT_LIMIT;

   `PGHA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))
   `PGHA_ASSERT_IMPLY(a_outside_zero, clock, reset, rsp_outside, rsp_zero)
   `PGHA_ASSERT_IMPLY(a_count_limit, clock, reset, rsp_valid, count_ok)
   `PGHA_ASSERT_NEXT(a_clear_blocks, clock, 1'b0, reset, !req_ready && !rsp_valid)

endmodule

bind point_grid_histogram_accumulator_core pgha_checker u_pgha_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

// ===== sim/point_grid_histogram_checker.sv =====
`timescale 1ns / 1ps

module point_grid_histogram_checker
   import pgha_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  req_type                   req_payload,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  rsp_type                   rsp_payload,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   output int                        outstanding,
   output int                        failures
);

   logic [15:0]        cell_counts [CELLS];
   logic signed [47:0] cell_sums   [CELLS];
   int                 grid_w;
   int                 grid_h;
   logic               sum_mode;
   rsp_type            awaited_cells [$];

   task automatic report_mismatch(input string field, input longint want, input longint got);
      failures++;
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
   endtask

   // Bin one point or read one cell, updating the grid copy.
   function automatic rsp_type bin_point(input req_type item);
      rsp_type     res;
      int          ew;
      int          eh;
      int          px;
      int          py;
      int          cell_idx;
      logic [15:0] cnt;
      longint      total;
      ew = (grid_w > MAX_WIDTH) ? MAX_WIDTH : grid_w;
      eh = (grid_h > MAX_HEIGHT) ? MAX_HEIGHT : grid_h;
      px = $signed(item.pixel_x);
      py = $signed(item.pixel_y);
      res = '0;
      res.status = ST_OUTSIDE;
      if (px < 0 || py < 0 || px >= ew || py >= eh)
         return res;
      cell_idx = py * MAX_WIDTH + px;
      cnt      = cell_counts[cell_idx];
      total    = $signed(cell_sums[cell_idx]);
      case (item.action)
         ACT_ACCUMULATE: begin
            if (sum_mode) begin
               if (item.attr_invalid) begin
                  res.status     = ST_SKIPPED;
                  res.cell_count = cnt;
                  res.cell_sum   = total[47:0];
                  return res;
               end
               total = total + longint'($signed(item.attr_value));
               if (total > longint'(SUM_HI))
                  total = longint'(SUM_HI);
               if (total < longint'(SUM_LO))
                  total = longint'(SUM_LO);
               cell_sums[cell_idx] = total[47:0];
            end
            cnt = (cnt >= COUNT_LIMIT) ? COUNT_LIMIT : cnt + 16'd1;
            cell_counts[cell_idx] = cnt;
            res.status = ST_ACCUMULATED;
         end
         default: begin
            res.status = ST_READ_DONE;
            if (item.action == ACT_READ_CLEAR) begin
               cell_counts[cell_idx] = '0;
               cell_sums[cell_idx]   = '0;
            end
         end
      endcase
      res.cell_count = cnt;
      res.cell_sum   = total[47:0];
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < CELLS; i++) begin
            cell_counts[i] = '0;
            cell_sums[i]   = '0;
         end
         grid_w   = MAX_WIDTH;
         grid_h   = MAX_HEIGHT;
         sum_mode = 1'b0;
         awaited_cells.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_cells.size() == 0) begin
               failures++;
               $error("response transfer with nothing expected, status %0d",
                      rsp_payload.status);
            end else begin
               want = awaited_cells.pop_front();
               if (rsp_payload.status !== want.status)
                  report_mismatch("status", want.status, rsp_payload.status);
               if (rsp_payload.cell_count !== want.cell_count)
                  report_mismatch("cell_count", want.cell_count, rsp_payload.cell_count);
               if (rsp_payload.cell_sum !== want.cell_sum)
                  report_mismatch("cell_sum", $signed(want.cell_sum),
                                  $signed(rsp_payload.cell_sum));
            end
         end
         if (req_valid && req_ready)
            awaited_cells.push_back(bin_point(req_payload));
         if (csr_write_en) begin
            case (csr_index)
               CSR_GRID_WIDTH:  grid_w = csr_data;
               CSR_GRID_HEIGHT: grid_h = csr_data;
               CSR_VALUE_MODE:  sum_mode = csr_data[0];
               default: ;
            endcase
         end
      end
      outstanding = awaited_cells.size();
   end

endmodule

// ===== sim/tb_point_grid_histogram_accumulator_core.sv =====
`timescale 1ns / 1ps

module tb_point_grid_histogram_accumulator_core;
   import pgha_pkg::*;

   localparam logic [1:0]                ACT_UNUSED    = 2'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED    = 2'd3;
   localparam int                        PHASE_ITEMS   = 220;
   localparam int                        HAMMER_ITEMS  = 40;
   localparam int                        SETTLE_CYCLES = 4;
   localparam int                        CYCLE_LIMIT   = 400000;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   req_type                   req_payload;
   logic                      rsp_valid;
   logic                      rsp_ready;
   rsp_type                   rsp_payload;
   logic                      csr_write_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;
   int                        outstanding;
   int                        mismatch_count;
   int                        req_idle_pct;
   int                        rsp_idle_pct;
   int                        grid_cols;
   int                        grid_rows;
   logic signed [15:0]        last_x;
   logic signed [15:0]        last_y;
   int                        cycles;

   point_grid_histogram_accumulator_core u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   point_grid_histogram_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .outstanding  (outstanding),
      .failures     (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   function automatic req_type make_req(input logic [1:0] action, input int x, input int y,
                                        input int attr, input logic invalid);
      req_type item;
      item.action       = action;
      item.pixel_x      = 16'(x);
      item.pixel_y      = 16'(y);
      item.attr_value   = attr;
      item.attr_invalid = invalid;
      return item;
   endfunction

   function automatic req_type random_item();
      req_type item;
      int      ew;
      int      eh;
      int      pick;
      ew = (grid_cols > MAX_WIDTH) ? MAX_WIDTH : grid_cols;
      eh = (grid_rows > MAX_HEIGHT) ? MAX_HEIGHT : grid_rows;
      pick = $urandom_range(99);
      if (pick < 55)
         item.action = ACT_ACCUMULATE;
      else if (pick < 75)
         item.action = ACT_READ;
      else if (pick < 92)
         item.action = ACT_READ_CLEAR;
      else
         item.action = ACT_UNUSED;
      pick = $urandom_range(99);
      if (pick < 70 && ew > 0 && eh > 0) begin
         item.pixel_x = 16'($urandom_range(ew - 1));
         item.pixel_y = 16'($urandom_range(eh - 1));
      end else if (pick < 82) begin
         item.pixel_x = last_x;
         item.pixel_y = last_y;
      end else if (pick < 92) begin
         case ($urandom_range(3))
            0: item.pixel_x = -16'sd1;
            1: item.pixel_x = 16'(ew);
            2: item.pixel_x = 16'(ew - 1);
            default: item.pixel_x = '0;
         endcase
         case ($urandom_range(3))
            0: item.pixel_y = -16'sd1;
            1: item.pixel_y = 16'(eh);
            2: item.pixel_y = 16'(eh - 1);
            default: item.pixel_y = '0;
         endcase
      end else begin
         item.pixel_x = 16'($urandom);
         item.pixel_y = 16'($urandom);
      end
      last_x = item.pixel_x;
      last_y = item.pixel_y;
      pick = $urandom_range(99);
      if (pick < 50)
         item.attr_value = $urandom;
      else if (pick < 70)
         case ($urandom_range(3))
            0: item.attr_value = 32'h7FFF_FFFF;
            1: item.attr_value = 32'h8000_0000;
            2: item.attr_value = '0;
            default: item.attr_value = '1;
         endcase
      else
         item.attr_value = int'($urandom_range(2097151)) - 1048576;
      item.attr_invalid = ($urandom_range(3) == 0);
      return item;
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_req(input req_type item);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Hold off the sender until every response is back.
   task automatic drain();
      req_valid <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_data     <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_grid(input int cols, input int rows, input logic mode);
      drain();
      write_csr(CSR_GRID_WIDTH, CSR_DATA_BITS'(cols));
      write_csr(CSR_GRID_HEIGHT, CSR_DATA_BITS'(rows));
      write_csr(CSR_VALUE_MODE, CSR_DATA_BITS'(mode));
      grid_cols = cols;
      grid_rows = rows;
   endtask

   task automatic hammer_cell(input int x, input int attr);
      send_req(make_req(ACT_READ_CLEAR, x, 0, 0, 1'b0));
      repeat (HAMMER_ITEMS) send_req(make_req(ACT_ACCUMULATE, x, 0, attr, 1'b0));
      send_req(make_req(ACT_READ, x, 0, 0, 1'b0));
   endtask

   task automatic run_random(input int count);
      repeat (count) send_req(random_item());
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_payload  = '0;
      rsp_ready    = 1'b0;
      csr_write_en = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      req_idle_pct = 6;
      rsp_idle_pct = 45;
      grid_cols    = MAX_WIDTH;
      grid_rows    = MAX_HEIGHT;
      last_x       = '0;
      last_y       = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      set_grid(128, 128, 1'b1);
      send_req(make_req(ACT_ACCUMULATE, 0, 0, 32'h7FFF_FFFF, 1'b0));
      send_req(make_req(ACT_ACCUMULATE, 0, 0, 32'h8000_0000, 1'b0));
      send_req(make_req(ACT_ACCUMULATE, 127, 127, 1, 1'b0));
      send_req(make_req(ACT_ACCUMULATE, 127, 127, 99, 1'b1));
      send_req(make_req(ACT_ACCUMULATE, 128, 0, 5, 1'b0));
      send_req(make_req(ACT_ACCUMULATE, 0, 128, 5, 1'b0));
      send_req(make_req(ACT_ACCUMULATE, -1, 0, 5, 1'b0));
      send_req(make_req(ACT_ACCUMULATE, 0, -1, 5, 1'b0));
      send_req(make_req(ACT_ACCUMULATE, -32768, 32767, 5, 1'b0));
      send_req(make_req(ACT_ACCUMULATE, 32767, -32768, 5, 1'b0));
      send_req(make_req(ACT_READ, 0, 0, 0, 1'b0));
      send_req(make_req(ACT_UNUSED, 127, 127, 0, 1'b0));
      send_req(make_req(ACT_READ_CLEAR, 0, 0, 0, 1'b0));
      send_req(make_req(ACT_READ, 0, 0, 0, 1'b0));
      send_req(make_req(ACT_READ_CLEAR, 200, 5, 0, 1'b0));
      send_req(make_req(ACT_ACCUMULATE, 5, 5, -65536, 1'b0));
      send_req(make_req(ACT_READ, 5, 5, 0, 1'b0));

      set_grid(128, 128, 1'b0);
      send_req(make_req(ACT_ACCUMULATE, 5, 5, $urandom, 1'b1));
      send_req(make_req(ACT_ACCUMULATE, 5, 5, 123, 1'b0));
      send_req(make_req(ACT_READ, 5, 5, 0, 1'b0));

      set_grid(0, 128, 1'b0);
      send_req(make_req(ACT_ACCUMULATE, 0, 0, 0, 1'b0));
      send_req(make_req(ACT_READ, 0, 0, 0, 1'b0));

      set_grid(255, 255, 1'b1);
      write_csr(CSR_UNUSED, '1);
      send_req(make_req(ACT_ACCUMULATE, 127, 127, 7, 1'b0));
      send_req(make_req(ACT_ACCUMULATE, 128, 5, 7, 1'b0));
      send_req(make_req(ACT_ACCUMULATE, 0, 0, 7, 1'b0));

      set_grid(128, 128, 1'b1);
      run_random(PHASE_ITEMS);

      drain();
      req_idle_pct = 45;
      rsp_idle_pct = 6;
      set_grid(1, 128, 1'b0);
      run_random(PHASE_ITEMS);

      drain();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      set_grid(2, 1, 1'b0);
      hammer_cell(0, 0);
      set_grid(2, 1, 1'b1);
      hammer_cell(0, 32'h7FFF_FFFF);
      hammer_cell(1, 32'h8000_0000);
      set_grid(13, 9, 1'b1);
      run_random(PHASE_ITEMS);

      drain();
      if (mismatch_count == 0 && outstanding == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
